// ===== hdl/rbts_pkg.sv =====
// ----------------------------------------------------------------------------
// rbts_pkg
// Shared widths, register codes, reset values and controller/datapath
// command and status types for the rolling band trade signal block.
// ----------------------------------------------------------------------------
`default_nettype none

package rbts_pkg;

   localparam int WINDOW_MAX_DEF = 64;

   localparam int PRICE_W    = 24;
   localparam int CASH_W     = 48;
   localparam int POS_W      = 11;
   localparam int LEN_W      = 7;
   localparam int LIMIT_W    = 10;
   localparam int MULT_W     = 5;
   localparam int PMAG_W     = 5;
   localparam int PSQ_W      = 9;
   localparam int ORDER_W    = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;
   localparam int LEN_MAX    = (1 << LEN_W) - 1;

   localparam logic [LEN_W-1:0]         WINDOW_LEN_RESET     = 7'd20;
   localparam logic [LIMIT_W-1:0]       POSITION_LIMIT_RESET = 10'd5;
   localparam logic signed [MULT_W-1:0] THRESHOLD_MULT_RESET = 5'sd2;

   typedef enum logic [ORDER_W-1:0] {
      ORDER_NONE = 2'd0,
      ORDER_BUY  = 2'd1,
      ORDER_SELL = 2'd2
   } order_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WINDOW_LEN     = 2'd0,
      CSR_POSITION_LIMIT = 2'd1,
      CSR_THRESHOLD_MULT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic accept;
      logic sum_step;
      logic square_step;
      logic product_step;
      logic spread_step;
      logic scale_step;
      logic trade_step;
      logic report_step;
   } dp_cmd_type;

   typedef struct packed {
      logic trade_enable;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== hdl/rolling_band_trade_signal.sv =====
// ----------------------------------------------------------------------------
// rolling_band_trade_signal
// Band breakout trader: windowed mean and spread per price, buy/sell one
// unit within a position limit, saturating cash and marked value.
// ----------------------------------------------------------------------------
// One price beat is taken at a time. A warm-up beat (trade_enable low) runs
// the ring read, sum update and square steps and then reports; a trading
// beat runs the ring read, sum update, square, product, spread, scale and
// trade steps, which the sequencer walks through one per cycle, before it
// reports. A beat's result is loaded before the next beat is taken.
// A finished result is held in an output register, and the next beat is
// taken while it waits, but its own result is not loaded until the
// waiting one is taken. The ring needs no clearing pass: a fill count
// marks unwritten entries, which read as zero. Writing window_len
// restarts the window; cash and position are kept. The configuration
// port is always ready and must be written only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module rolling_band_trade_signal
   import rbts_pkg::*;
#(
   parameter int WINDOW_MAX = WINDOW_MAX_DEF
)
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_stall,
   input  wire logic [PRICE_W-1:0]      req_close_price,
   input  wire logic                    req_trade_enable,
   output      logic                    rsp_valid,
   input  wire logic                    rsp_stall,
   output      logic [ORDER_W-1:0]      rsp_order,
   output      logic [PRICE_W-1:0]      rsp_order_price,
   output      logic signed [CASH_W-1:0] rsp_cash_balance,
   output      logic signed [POS_W-1:0]  rsp_held_position,
   output      logic signed [CASH_W-1:0] rsp_marked_value,
   input  wire logic                    csr_valid,
   output      logic                    csr_ready,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   rbts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   rbts_datapath #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_close_price   (req_close_price),
      .req_trade_enable  (req_trade_enable),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_order         (rsp_order),
      .rsp_order_price   (rsp_order_price),
      .rsp_cash_balance  (rsp_cash_balance),
      .rsp_held_position (rsp_held_position),
      .rsp_marked_value  (rsp_marked_value)
   );

endmodule

`default_nettype wire

// ===== hdl/rbts_ctrl.sv =====
// ----------------------------------------------------------------------------
// rbts_ctrl
// Step sequencer: accepts one beat, walks the datapath through the window
// update and, for trading beats, the band test and trade steps, and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module rbts_ctrl
   import rbts_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output      logic          req_stall,
   output      logic          rsp_valid,
   input  wire logic          rsp_stall,
   output      dp_cmd_type    cmd,
   input  wire dp_status_type status
);

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_SUM     = 8'b0000_0010,
      ST_SQUARE  = 8'b0000_0100,
      ST_PRODUCT = 8'b0000_1000,
      ST_SPREAD  = 8'b0001_0000,
      ST_SCALE   = 8'b0010_0000,
      ST_TRADE   = 8'b0100_0000,
      ST_REPORT  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      load;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign load      = (state_ff == ST_REPORT) && !(rsp_valid_ff && rsp_stall);

   always_comb begin
      cmd              = '0;
      cmd.accept       = (state_ff == ST_IDLE) && req_valid;
      cmd.sum_step     = (state_ff == ST_SUM);
      cmd.square_step  = (state_ff == ST_SQUARE);
      cmd.product_step = (state_ff == ST_PRODUCT);
      cmd.spread_step  = (state_ff == ST_SPREAD);
      cmd.scale_step   = (state_ff == ST_SCALE);
      cmd.trade_step   = (state_ff == ST_TRADE);
      cmd.report_step  = load;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SUM;
         end
         ST_SUM:     state_in = ST_SQUARE;
         ST_SQUARE:  state_in = status.trade_enable ? ST_PRODUCT : ST_REPORT;
         ST_PRODUCT: state_in = ST_SPREAD;
         ST_SPREAD:  state_in = ST_SCALE;
         ST_SCALE:   state_in = ST_TRADE;
         ST_TRADE:   state_in = ST_REPORT;
         ST_REPORT: begin
            if (load) state_in = ST_IDLE;
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/rbts_datapath.sv =====
// ----------------------------------------------------------------------------
// rbts_datapath
// Price ring, running sum and sum of squares, rootless band test, order
// decision with position limit, saturating cash and marked value.
// ----------------------------------------------------------------------------
`default_nettype none

module rbts_datapath
   import rbts_pkg::*;
#(
   parameter int WINDOW_MAX = WINDOW_MAX_DEF
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire dp_cmd_type             cmd,
   output      dp_status_type          status,
   input  wire logic [PRICE_W-1:0]     req_close_price,
   input  wire logic                   req_trade_enable,
   input  wire logic                   csr_valid,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   output      logic [ORDER_W-1:0]     rsp_order,
   output      logic [PRICE_W-1:0]     rsp_order_price,
   output      logic signed [CASH_W-1:0] rsp_cash_balance,
   output      logic signed [POS_W-1:0]  rsp_held_position,
   output      logic signed [CASH_W-1:0] rsp_marked_value
);

   localparam int PTR_W  = $clog2(WINDOW_MAX);
   localparam int FILL_W = $clog2(WINDOW_MAX + 1);
   localparam int MAXLEN = (WINDOW_MAX < LEN_MAX) ? WINDOW_MAX : LEN_MAX;
   localparam int CNT_W  = $clog2(MAXLEN + 1);
   localparam int SUM_W  = PRICE_W + CNT_W;
   localparam int SQ_W   = 2 * PRICE_W + CNT_W;
   localparam int A_W    = SUM_W + 1;
   localparam int D_W    = 2 * SUM_W;
   localparam int RHS_W  = D_W + PSQ_W;
   localparam int LC_W   = LEN_W + PRICE_W;
   localparam int LQ_W   = LEN_W + SQ_W;
   localparam int EXT_W  = ((PTR_W > LEN_W) ? PTR_W : LEN_W) + 1;
   localparam int PROD_W = POS_W + PRICE_W + 1;

   localparam logic [LEN_W-1:0]  LEN_CAP  = LEN_W'(MAXLEN);
   localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(WINDOW_MAX - 1);
   localparam logic [FILL_W-1:0] FILL_TOP = FILL_W'(WINDOW_MAX);
   localparam logic [EXT_W-1:0]  WM_EXT   = EXT_W'(WINDOW_MAX);

   function automatic logic signed [CASH_W-1:0] sat_cash(input logic signed [CASH_W:0] v);
      logic signed [CASH_W-1:0] r;
      r = v[CASH_W-1:0];
      if (v[CASH_W] != v[CASH_W-1]) begin
         r = v[CASH_W] ? {1'b1, {(CASH_W-1){1'b0}}} : {1'b0, {(CASH_W-1){1'b1}}};
      end
      return r;
   endfunction

   // configuration
   logic [LEN_W-1:0]         window_len_ff;
   logic [LIMIT_W-1:0]       limit_ff;
   logic signed [MULT_W-1:0] mult_ff;

   // window state
   logic [PRICE_W-1:0] ring_mem [WINDOW_MAX];
   logic [PTR_W-1:0]   ptr_ff;
   logic [FILL_W-1:0]  fill_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [SQ_W-1:0]    sqsum_ff;

   // trading state
   logic signed [CASH_W-1:0] cash_ff;
   logic signed [POS_W-1:0]  pos_ff;

   // per item working registers
   logic [PRICE_W-1:0]     close_ff;
   logic                   trade_ff;
   logic [2*PRICE_W-1:0]   csq_ff;
   logic [2*PRICE_W-1:0]   lsq_ff;
   logic [PRICE_W-1:0]     rd_ff;
   logic                   leave_valid_ff;
   logic [D_W-1:0]         ss_ff;
   logic [D_W-1:0]         lq_ff;
   logic [D_W-1:0]         d_ff;
   logic signed [A_W-1:0]  a_ff;
   logic [D_W-1:0]         asq_ff;
   logic [RHS_W-1:0]       rhs_ff;
   order_type              order_ff;

   // result registers
   logic [ORDER_W-1:0]       rsp_order_ff;
   logic [PRICE_W-1:0]       rsp_price_ff;
   logic signed [CASH_W-1:0] rsp_cash_ff;
   logic signed [POS_W-1:0]  rsp_pos_ff;
   logic signed [CASH_W-1:0] rsp_marked_ff;

   logic [LEN_W-1:0]         len_eff;
   logic [EXT_W-1:0]         ptr_ext, len_ext, leave_ext;
   logic [PTR_W-1:0]         leave_idx;
   logic                     leave_valid;
   logic [PRICE_W-1:0]       leave_price;
   logic [LC_W-1:0]          len_close;
   logic [LQ_W-1:0]          len_sq;
   logic [SUM_W-1:0]         amag;
   logic [PMAG_W-1:0]        pmag;
   logic [2*PMAG_W-1:0]      psq;
   logic                     a_pos, a_zero, band_true;
   logic signed [POS_W:0]    pos_x, lim_x;
   logic                     buy_ok, sell_ok;
   logic signed [CASH_W:0]   cash_x, close_x;
   logic signed [PROD_W-1:0] mark_prod;
   logic signed [CASH_W:0]   mark_sum;

   assign status.trade_enable = trade_ff;

   always_comb begin
      len_eff = window_len_ff;
      if (window_len_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (window_len_ff > LEN_CAP) begin
         len_eff = LEN_CAP;
      end
   end

   assign ptr_ext     = EXT_W'(ptr_ff);
   assign len_ext     = EXT_W'(len_eff);
   assign leave_ext   = (ptr_ext >= len_ext) ? (ptr_ext - len_ext) : (ptr_ext + WM_EXT - len_ext);
   assign leave_idx   = leave_ext[PTR_W-1:0];
   assign leave_valid = FILL_W'(leave_idx) < fill_ff;
   assign leave_price = leave_valid_ff ? rd_ff : '0;

   assign len_close = len_eff * close_ff;
   assign len_sq    = len_eff * sqsum_ff;
   assign amag      = a_ff[A_W-1] ? SUM_W'(-a_ff) : SUM_W'(a_ff);
   assign pmag      = mult_ff[MULT_W-1] ? PMAG_W'(-mult_ff) : PMAG_W'(mult_ff);
   assign psq       = pmag * pmag;

   assign a_zero = (a_ff == '0);
   assign a_pos  = !a_ff[A_W-1] && !a_zero;

   always_comb begin
      if (mult_ff == '0) begin
         band_true = a_pos;
      end else if (!mult_ff[MULT_W-1]) begin
         band_true = a_pos && (RHS_W'(asq_ff) > rhs_ff);
      end else if (a_pos) begin
         band_true = 1'b1;
      end else if (a_zero) begin
         band_true = (d_ff != '0);
      end else begin
         band_true = (RHS_W'(asq_ff) < rhs_ff);
      end
   end

   assign pos_x   = {pos_ff[POS_W-1], pos_ff};
   assign lim_x   = $signed({1'b0, 1'b0, limit_ff});
   assign buy_ok  = (pos_x < lim_x) && (pos_x >= -lim_x);
   assign sell_ok = (pos_x <= lim_x) && (pos_x > -lim_x);
   assign cash_x  = {cash_ff[CASH_W-1], cash_ff};
   assign close_x = $signed({{(CASH_W+1-PRICE_W){1'b0}}, close_ff});

   assign mark_prod = pos_ff * $signed({1'b0, close_ff});
   assign mark_sum  = cash_x + {{(CASH_W+1-PROD_W){mark_prod[PROD_W-1]}}, mark_prod};

   // ring memory: read leaving price and write new price on the same beat
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         ring_mem[ptr_ff] <= req_close_price;
         rd_ff            <= ring_mem[leave_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff <= WINDOW_LEN_RESET;
         limit_ff      <= POSITION_LIMIT_RESET;
         mult_ff       <= THRESHOLD_MULT_RESET;
         ptr_ff        <= '0;
         fill_ff       <= '0;
         sum_ff        <= '0;
         sqsum_ff      <= '0;
         cash_ff       <= '0;
         pos_ff        <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_WINDOW_LEN: begin
                  window_len_ff <= csr_data[LEN_W-1:0];
                  ptr_ff        <= '0;
                  fill_ff       <= '0;
                  sum_ff        <= '0;
                  sqsum_ff      <= '0;
               end
               CSR_POSITION_LIMIT: limit_ff <= csr_data[LIMIT_W-1:0];
               CSR_THRESHOLD_MULT: mult_ff  <= $signed(csr_data[MULT_W-1:0]);
               default: ;
            endcase
         end
         if (cmd.accept) begin
            ptr_ff <= (ptr_ff == PTR_LAST) ? '0 : ptr_ff + PTR_W'(1);
            if (fill_ff != FILL_TOP) fill_ff <= fill_ff + FILL_W'(1);
         end
         if (cmd.sum_step) begin
            sum_ff <= sum_ff - SUM_W'(leave_price) + SUM_W'(close_ff);
         end
         if (cmd.square_step) begin
            sqsum_ff <= sqsum_ff - SQ_W'(lsq_ff) + SQ_W'(csq_ff);
         end
         if (cmd.trade_step) begin
            if (band_true) begin
               if (buy_ok) begin
                  cash_ff <= sat_cash(cash_x - close_x);
                  pos_ff  <= pos_ff + POS_W'(1);
               end
            end else if (sell_ok) begin
               cash_ff <= sat_cash(cash_x + close_x);
               pos_ff  <= pos_ff - POS_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         close_ff       <= req_close_price;
         trade_ff       <= req_trade_enable;
         csq_ff         <= req_close_price * req_close_price;
         leave_valid_ff <= leave_valid;
         order_ff       <= ORDER_NONE;
      end
      if (cmd.sum_step) begin
         lsq_ff <= leave_price * leave_price;
      end
      if (cmd.square_step) begin
         ss_ff <= sum_ff * sum_ff;
      end
      if (cmd.product_step) begin
         lq_ff <= len_sq[D_W-1:0];
         a_ff  <= $signed(A_W'(len_close)) - $signed({1'b0, sum_ff});
      end
      if (cmd.spread_step) begin
         d_ff   <= (lq_ff > ss_ff) ? (lq_ff - ss_ff) : '0;
         asq_ff <= amag * amag;
      end
      if (cmd.scale_step) begin
         rhs_ff <= d_ff * psq[PSQ_W-1:0];
      end
      if (cmd.trade_step) begin
         if (band_true) begin
            if (buy_ok) order_ff <= ORDER_BUY;
         end else if (sell_ok) begin
            order_ff <= ORDER_SELL;
         end
      end
      if (cmd.report_step) begin
         rsp_order_ff  <= order_ff;
         rsp_price_ff  <= close_ff;
         rsp_cash_ff   <= cash_ff;
         rsp_pos_ff    <= pos_ff;
         rsp_marked_ff <= sat_cash(mark_sum);
      end
   end

   assign rsp_order         = rsp_order_ff;
   assign rsp_order_price   = rsp_price_ff;
   assign rsp_cash_balance  = rsp_cash_ff;
   assign rsp_held_position = rsp_pos_ff;
   assign rsp_marked_value  = rsp_marked_ff;

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the rolling band trade signal block. Price beats
// are driven with random pacing and each result beat is checked against an
// in-bench band and trade predictor. It covers reset defaults, register
// extremes, the position limit and threshold signs, and then random price
// walks over random register settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   import rbts_pkg::*;

   localparam int RING_DEPTH  = 64;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_COUNT = 8;
   localparam int PHASE_BEATS = 62;
   localparam int FILL_DEPTH  = 8;
   localparam longint CASH_TOP    = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint CASH_BOTTOM = -CASH_TOP - 64'sd1;

   typedef struct {
      order_type           order;
      logic [PRICE_W-1:0]  price;
      logic [CASH_W-1:0]   cash;
      logic [POS_W-1:0]    position;
      logic [CASH_W-1:0]   marked;
   } fill_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [PRICE_W-1:0]       req_close_price = '0;
   logic                     req_trade_enable = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [ORDER_W-1:0]       rsp_order;
   logic [PRICE_W-1:0]       rsp_order_price;
   logic signed [CASH_W-1:0] rsp_cash_balance;
   logic signed [POS_W-1:0]  rsp_held_position;
   logic signed [CASH_W-1:0] rsp_marked_value;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_data = '0;

   logic [PRICE_W-1:0]       price_window [RING_DEPTH];
   logic [5:0]               window_head;
   logic [63:0]              price_sum;
   logic [63:0]              square_sum;
   longint                   held_units = 0;
   longint                   cash_now = 0;
   logic [LEN_W-1:0]         cfg_len = WINDOW_LEN_RESET;
   logic [LIMIT_W-1:0]       cfg_limit = POSITION_LIMIT_RESET;
   logic signed [MULT_W-1:0] cfg_mult = THRESHOLD_MULT_RESET;
   fill_type                 fill_store [FILL_DEPTH];
   int                       fill_wr_count = 0;
   int                       fill_rd_count = 0;

   int     fail_count = 0;
   int     beat_count = 0;
   int     buy_count = 0;
   int     sell_count = 0;
   int     setting_count = 0;
   longint cycle_count = 0;
   bit     pace_on = 1'b1;

   rolling_band_trade_signal dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_close_price   (req_close_price),
      .req_trade_enable  (req_trade_enable),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_order         (rsp_order),
      .rsp_order_price   (rsp_order_price),
      .rsp_cash_balance  (rsp_cash_balance),
      .rsp_held_position (rsp_held_position),
      .rsp_marked_value  (rsp_marked_value),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("rolling_band_trade_signal verification failed");
         $finish;
      end
   end

   function automatic longint clip48(longint v);
      if (v > CASH_TOP) return CASH_TOP;
      if (v < CASH_BOTTOM) return CASH_BOTTOM;
      return v;
   endfunction

   // close - mean > mult * sd, compared as squares with the signs handled
   function automatic bit above_band(longint dev, int mult, logic [127:0] spread);
      logic [127:0] dev_mag;
      logic [127:0] dev_sq;
      logic [127:0] bound;
      dev_mag = (dev < 0) ? 128'(-dev) : 128'(dev);
      dev_sq  = dev_mag * dev_mag;
      bound   = spread * 128'(mult * mult);
      if (mult == 0) return dev > 0;
      if (mult > 0) return (dev > 0) && (dev_sq > bound);
      if (dev > 0) return 1'b1;
      if (dev == 0) return spread != 0;
      return dev_sq < bound;
   endfunction

   function automatic logic [PRICE_W-1:0] next_walk(logic [PRICE_W-1:0] price);
      longint moved;
      moved = longint'(price) + (($urandom_range(0, 1) != 0) ? 64'sd1 : -64'sd1) *
              longint'(1 << $urandom_range(0, 14));
      if (moved < 0) moved = 0;
      if (moved > longint'({PRICE_W{1'b1}})) moved = longint'({PRICE_W{1'b1}});
      return PRICE_W'(moved);
   endfunction

   task automatic restart_window();
      for (int i = 0; i < RING_DEPTH; i++) price_window[i] = '0;
      window_head = '0;
      price_sum   = '0;
      square_sum  = '0;
   endtask

   task automatic predict_fill(input logic [PRICE_W-1:0] close, input logic trade);
      int           span;
      logic [5:0]   leave_idx;
      logic [63:0]  close_w;
      logic [63:0]  leaving;
      longint       dev;
      longint       lim;
      logic [127:0] scaled_sq;
      logic [127:0] sum_sq;
      logic [127:0] spread;
      fill_type     fill;
      span = (cfg_len == 0) ? 1 : ((cfg_len > RING_DEPTH) ? RING_DEPTH : int'(cfg_len));
      leave_idx = window_head - 6'(span);
      close_w   = 64'(close);
      leaving   = 64'(price_window[leave_idx]);
      price_window[window_head] = close;
      price_sum   = price_sum - leaving + close_w;
      square_sum  = square_sum - leaving * leaving + close_w * close_w;
      window_head = window_head + 6'd1;
      fill.order  = ORDER_NONE;
      if (trade) begin
         dev       = longint'(64'(span) * close_w) - longint'(price_sum);
         scaled_sq = 128'(span) * 128'(square_sum);
         sum_sq    = 128'(price_sum) * 128'(price_sum);
         spread    = (scaled_sq > sum_sq) ? scaled_sq - sum_sq : 128'd0;
         lim       = longint'(cfg_limit);
         if (above_band(dev, int'(cfg_mult), spread)) begin
            if (held_units < lim && held_units >= -lim) begin
               fill.order = ORDER_BUY;
               cash_now   = clip48(cash_now - longint'(close_w));
               held_units = held_units + 1;
            end
         end else if (held_units <= lim && held_units > -lim) begin
            fill.order = ORDER_SELL;
            cash_now   = clip48(cash_now + longint'(close_w));
            held_units = held_units - 1;
         end
      end
      fill.price    = close;
      fill.cash     = CASH_W'(cash_now);
      fill.position = POS_W'(held_units);
      fill.marked   = CASH_W'(clip48(cash_now + held_units * longint'(close_w)));
      fill_store[fill_wr_count % FILL_DEPTH] = fill;
      fill_wr_count++;
   endtask

   task automatic send_price(input logic [PRICE_W-1:0] close, input logic trade);
      int gap;
      gap = pace_on ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_close_price  <= close;
      req_trade_enable <= trade;
      do @(posedge clock); while (req_stall !== 1'b0);
      predict_fill(close, trade);
      beat_count++;
   endtask

   task automatic drain_fills();
      req_valid <= 1'b0;
      while (fill_wr_count != fill_rd_count) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
   endtask

   // upper data bits beyond the window length and threshold widths carry noise
   task automatic program_config(input int span, input int cap, input int mult);
      write_register(CSR_WINDOW_LEN, {3'($urandom), 7'(span)});
      cfg_len = 7'(span);
      restart_window();
      write_register(CSR_POSITION_LIMIT, 10'(cap));
      cfg_limit = 10'(cap);
      write_register(CSR_THRESHOLD_MULT, {5'($urandom), 5'(mult)});
      cfg_mult = MULT_W'(mult);
      csr_valid <= 1'b0;
      setting_count++;
   endtask

   task automatic compare_field(input string label, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, label, want, got);
         fail_count++;
      end
   endtask

   initial begin : fill_checker
      fill_type want;
      int       hold;
      forever begin
         hold = pace_on ? $urandom_range(0, 14) : 0;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1 || reset);
         if (fill_wr_count == fill_rd_count) begin
            $display("%0t: result beat with nothing expected, expected none, got order %0h",
                     $time, rsp_order);
            fail_count++;
         end else begin
            want = fill_store[fill_rd_count % FILL_DEPTH];
            fill_rd_count++;
            if (want.order == ORDER_BUY) buy_count++;
            if (want.order == ORDER_SELL) sell_count++;
            compare_field("order", 64'(want.order), 64'(rsp_order));
            compare_field("order_price", 64'(want.price), 64'(rsp_order_price));
            compare_field("cash_balance", 64'(want.cash), 64'($unsigned(rsp_cash_balance)));
            compare_field("held_position", 64'(want.position),
                          64'($unsigned(rsp_held_position)));
            compare_field("marked_value", 64'(want.marked), 64'($unsigned(rsp_marked_value)));
         end
      end
   end

   task automatic test_reset_defaults();
      send_price(24'h000100, 1'b0);
      send_price(24'hFFFFFF, 1'b0);
      send_price(24'hFFFFFF, 1'b1);
      send_price(24'h000000, 1'b1);
      send_price(24'h800000, 1'b1);
      drain_fills();
   endtask

   task automatic test_window_extremes();
      program_config(0, 5, 2);
      send_price(24'h123456, 1'b1);
      send_price(24'h123456, 1'b1);
      drain_fills();
      program_config(127, 1023, -8);
      send_price(24'h000001, 1'b1);
      send_price(24'h400000, 1'b1);
      send_price(24'hFFFFFF, 1'b1);
      drain_fills();
      program_config(RING_DEPTH, 0, 0);
      send_price(24'h00FF00, 1'b1);
      send_price(24'hFF00FF, 1'b1);
      drain_fills();
   endtask

   task automatic test_limit_lowered();
      program_config(4, 3, -1);
      for (int k = 1; k <= 4; k++) send_price(PRICE_W'(k * 24'h010000), 1'b1);
      drain_fills();
      program_config(4, 1, 8);
      repeat (3) send_price(24'h020000, 1'b1);
      drain_fills();
   endtask

   task automatic test_threshold_signs();
      program_config(2, 20, -8);
      send_price(24'h00ABCD, 1'b0);
      send_price(24'h00ABCD, 1'b1);
      send_price(24'h00ABCC, 1'b1);
      drain_fills();
      program_config(2, 20, 0);
      send_price(24'h00ABCD, 1'b1);
      send_price(24'h00ABCE, 1'b1);
      drain_fills();
      program_config(2, 20, 8);
      send_price(24'hFFFFFF, 1'b1);
      send_price(24'hFFFFFE, 1'b1);
      drain_fills();
   endtask

   task automatic test_random_walk();
      logic [PRICE_W-1:0] price;
      int                 span;
      int                 cap;
      int                 style;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case ($urandom_range(0, 7))
            0:       span = 0;
            1:       span = 127;
            2:       span = RING_DEPTH;
            3:       span = 1;
            default: span = $urandom_range(2, 24);
         endcase
         case ($urandom_range(0, 3))
            0:       cap = 0;
            1:       cap = 1023;
            default: cap = $urandom_range(1, 12);
         endcase
         program_config(span, cap, int'($urandom_range(0, 16)) - 8);
         pace_on = ($urandom_range(0, 3) != 0);
         price = PRICE_W'($urandom);
         // fill the window before trading in about half of the phases
         if ($urandom_range(0, 1) != 0) begin
            repeat ((span > RING_DEPTH) ? RING_DEPTH : span) begin
               price = next_walk(price);
               send_price(price, 1'b0);
            end
         end
         for (int k = 0; k < PHASE_BEATS; k++) begin
            style = $urandom_range(0, 9);
            if (style == 0) price = PRICE_W'($urandom);
            else if (style > 1) price = next_walk(price);
            send_price(price, $urandom_range(0, 4) != 0);
         end
         drain_fills();
      end
   endtask

   initial begin
      restart_window();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_window_extremes();
      test_limit_lowered();
      test_threshold_signs();
      test_random_walk();
      $display("Checked %0d price beats over %0d register settings (%0d buys, %0d sells).",
               beat_count, setting_count, buy_count, sell_count);
      if (fail_count == 0) begin
         $display("rolling_band_trade_signal verification clean");
      end else begin
         $display("rolling_band_trade_signal verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
